### rtl/core/rpn_stack_calculator_unit_defines.svh
// ----------------------------------------------------------------------------
// rpn stack calculator assertion macros
// shared concurrent assertion forms, sampled on clk_i, off during reset
// ----------------------------------------------------------------------------
`ifndef RPN_STACK_CALCULATOR_UNIT_DEFINES_SVH
`define RPN_STACK_CALCULATOR_UNIT_DEFINES_SVH

// same-cycle implication
`define RPN_ASSERT_NOW(lbl, pre, post) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |-> (post)) \
    else $error("rpn checker: same-cycle property violated");

// next-cycle implication
`define RPN_ASSERT_NEXT(lbl, pre, post) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error("rpn checker: next-cycle property violated");

`endif

### rtl/core/rpn_pkg.sv
// ----------------------------------------------------------------------------
// rpn calculator package
// sizes, character codes, operation and status codes, control bundles
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package rpn_pkg;

  localparam int unsigned STACK_DEPTH = 64;
  localparam int unsigned DATA_W      = 32;
  localparam int unsigned DEPTH_W     = $clog2(STACK_DEPTH + 1);
  localparam int unsigned ADDR_W      = $clog2(STACK_DEPTH);

  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_NINE  = 8'h39;
  localparam logic [7:0] CHAR_PLUS  = 8'h2B;
  localparam logic [7:0] CHAR_MINUS = 8'h2D;
  localparam logic [7:0] CHAR_TIMES = 8'h2A;
  localparam logic [7:0] CHAR_DIV   = 8'h2F;
  localparam logic [7:0] CHAR_EQUAL = 8'h3D;

  typedef enum logic [1:0] {
    OP_ADD = 2'd0,
    OP_SUB = 2'd1,
    OP_MUL = 2'd2,
    OP_DIV = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_VALUE     = 2'd0,
    ST_UNDERFLOW = 2'd1,
    ST_OVERFLOW  = 2'd2,
    ST_DIVZERO   = 2'd3
  } status_e;

  typedef struct packed {
    logic              mem_we;
    logic              mem_re;
    logic [ADDR_W-1:0] mem_addr;
    logic              wsel_digit;
    logic              load_a;
    logic              load_b;
    logic              alu_go;
    op_e               alu_op;
    logic              div_start;
    logic              out_load;
    status_e           out_status;
  } ctrl_cmd_t;

  typedef struct packed {
    logic a_zero;
    logic div_done;
    logic out_free;
  } dp_status_t;

endpackage

`default_nettype wire

### rtl/core/rpn_ifs.sv
// ----------------------------------------------------------------------------
// rpn calculator channels
// character input channel and result output channel, valid/ready
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface rpn_char_if;
  logic       valid;
  logic       ready;
  logic [7:0] character;

  modport source (output valid, output character, input ready);
  modport sink   (input valid, input character, output ready);
endinterface

interface rpn_res_if;
  logic               valid;
  logic               ready;
  logic [1:0]         status;
  logic signed [31:0] result_value;

  modport source (output valid, output status, output result_value, input ready);
  modport sink   (input valid, input status, input result_value, output ready);
endinterface

`default_nettype wire

### rtl/core/rpn_div.sv
// ----------------------------------------------------------------------------
// rpn signed divider
// radix-2 restoring divider, truncates toward zero, one quotient bit a cycle
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rpn_div
  import rpn_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start_i,
  input  wire logic [DATA_W-1:0] num_i,
  input  wire logic [DATA_W-1:0] den_i,
  output logic                   done_o,
  output logic      [DATA_W-1:0] quot_o
);

  localparam int unsigned CNT_W = $clog2(DATA_W);

  logic              busy_q, done_q, neg_q;
  logic [CNT_W-1:0]  cnt_q;
  logic [DATA_W-1:0] rem_q, quo_q, den_q;
  logic [DATA_W:0]   trial;
  logic [DATA_W-1:0] num_mag, den_mag;

  assign num_mag = num_i[DATA_W-1] ? (DATA_W'(0) - num_i) : num_i;
  assign den_mag = den_i[DATA_W-1] ? (DATA_W'(0) - den_i) : den_i;
  assign trial   = {rem_q, quo_q[DATA_W-1]} - {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + CNT_W'(1);
        if (cnt_q == CNT_W'(DATA_W - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      quo_q <= num_mag;
      den_q <= den_mag;
      neg_q <= num_i[DATA_W-1] ^ den_i[DATA_W-1];
    end else if (busy_q) begin
      if (!trial[DATA_W]) begin
        rem_q <= trial[DATA_W-1:0];
        quo_q <= {quo_q[DATA_W-2:0], 1'b1};
      end else begin
        rem_q <= {rem_q[DATA_W-2:0], quo_q[DATA_W-1]};
        quo_q <= {quo_q[DATA_W-2:0], 1'b0};
      end
    end
  end

  assign done_o = done_q;
  assign quot_o = neg_q ? (DATA_W'(0) - quo_q) : quo_q;

endmodule

`default_nettype wire

### rtl/core/rpn_datapath.sv
// ----------------------------------------------------------------------------
// rpn datapath
// operand stack memory, operand registers, alu, divider and result register
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rpn_datapath
  import rpn_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic [7:0]         character_i,
  input  wire ctrl_cmd_t          cmd_i,
  output dp_status_t              status_o,
  output logic                    res_valid_o,
  input  wire logic               res_ready_i,
  output logic [1:0]              res_status_o,
  output logic [DATA_W-1:0]       res_value_o
);

  logic [DATA_W-1:0] stack_mem [STACK_DEPTH];
  logic [DATA_W-1:0] rdata_q;
  logic [DATA_W-1:0] a_q, b_q, res_q;
  logic [DATA_W-1:0] wdata, alu_res, quot;
  logic [7:0]        digit;
  logic              div_done;
  logic              out_valid_q;
  status_e           out_status_q;
  logic [DATA_W-1:0] out_value_q;

  // stack memory, one port
  assign digit = character_i - CHAR_ZERO;
  assign wdata = cmd_i.wsel_digit ? DATA_W'(digit) : res_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.mem_we) begin
      stack_mem[cmd_i.mem_addr] <= wdata;
    end
    if (cmd_i.mem_re) begin
      rdata_q <= stack_mem[cmd_i.mem_addr];
    end
  end

  always_comb begin
    unique case (cmd_i.alu_op)
      OP_ADD:  alu_res = b_q + a_q;
      OP_SUB:  alu_res = b_q - a_q;
      OP_MUL:  alu_res = DATA_W'(b_q * a_q);
      default: alu_res = b_q;
    endcase
  end

  rpn_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.div_start),
    .num_i   (b_q),
    .den_i   (a_q),
    .done_o  (div_done),
    .quot_o  (quot)
  );

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_a) begin
      a_q <= rdata_q;
    end
    if (cmd_i.load_b) begin
      b_q <= rdata_q;
    end
    if (div_done) begin
      res_q <= quot;
    end else if (cmd_i.alu_go) begin
      res_q <= alu_res;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (res_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_status_q <= cmd_i.out_status;
      out_value_q  <= (cmd_i.out_status == ST_VALUE) ? rdata_q : '0;
    end
  end

  assign status_o.a_zero   = (a_q == '0);
  assign status_o.div_done = div_done;
  assign status_o.out_free = !out_valid_q || res_ready_i;

  assign res_valid_o  = out_valid_q;
  assign res_status_o = out_status_q;
  assign res_value_o  = out_value_q;

endmodule

`default_nettype wire

### rtl/core/rpn_ctrl.sv
// ----------------------------------------------------------------------------
// rpn controller
// character decode, stack depth tracking and sequencing of the datapath
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rpn_ctrl
  import rpn_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  input  wire logic [7:0] character_i,
  output logic            in_ready_o,
  input  wire dp_status_t status_i,
  output ctrl_cmd_t       cmd_o
);

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_POP_A = 7'b0000010,
    S_POP_B = 7'b0000100,
    S_EXEC  = 7'b0001000,
    S_DIV   = 7'b0010000,
    S_WRITE = 7'b0100000,
    S_EMIT  = 7'b1000000
  } state_e;

  state_e             state_q, state_d;
  logic [DEPTH_W-1:0] depth_q, depth_d;
  op_e                op_q, op_d;
  status_e            emit_q, emit_d;
  logic [DEPTH_W-1:0] depth_m1, depth_m2;
  logic               is_digit, is_equal, is_op;
  op_e                char_op;

  assign depth_m1 = depth_q - DEPTH_W'(1);
  assign depth_m2 = depth_q - DEPTH_W'(2);

  assign is_digit = (character_i >= CHAR_ZERO) && (character_i <= CHAR_NINE);
  assign is_equal = (character_i == CHAR_EQUAL);
  assign is_op    = (character_i == CHAR_PLUS) || (character_i == CHAR_MINUS) ||
                    (character_i == CHAR_TIMES) || (character_i == CHAR_DIV);

  always_comb begin
    priority if (character_i == CHAR_PLUS) begin
      char_op = OP_ADD;
    end else if (character_i == CHAR_MINUS) begin
      char_op = OP_SUB;
    end else if (character_i == CHAR_TIMES) begin
      char_op = OP_MUL;
    end else begin
      char_op = OP_DIV;
    end
  end

  assign in_ready_o = (state_q == S_IDLE);

  always_comb begin
    state_d = state_q;
    depth_d = depth_q;
    op_d    = op_q;
    emit_d  = emit_q;

    cmd_o            = '0;
    cmd_o.mem_addr   = depth_m1[ADDR_W-1:0];
    cmd_o.alu_op     = op_q;
    cmd_o.out_status = emit_q;

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          priority if (is_digit) begin
            if (depth_q == DEPTH_W'(STACK_DEPTH)) begin
              emit_d  = ST_OVERFLOW;
              depth_d = '0;
              state_d = S_EMIT;
            end else begin
              cmd_o.mem_we     = 1'b1;
              cmd_o.wsel_digit = 1'b1;
              cmd_o.mem_addr   = depth_q[ADDR_W-1:0];
              depth_d          = depth_q + DEPTH_W'(1);
            end
          end else if (is_equal) begin
            if (depth_q == '0) begin
              emit_d = ST_UNDERFLOW;
            end else begin
              cmd_o.mem_re = 1'b1;
              emit_d       = ST_VALUE;
            end
            state_d = S_EMIT;
          end else if (is_op) begin
            if (depth_q < DEPTH_W'(2)) begin
              emit_d  = ST_UNDERFLOW;
              depth_d = '0;
              state_d = S_EMIT;
            end else begin
              cmd_o.mem_re = 1'b1;
              op_d         = char_op;
              state_d      = S_POP_A;
            end
          end else begin
            state_d = S_IDLE;
          end
        end
      end
      S_POP_A: begin
        cmd_o.load_a   = 1'b1;
        cmd_o.mem_re   = 1'b1;
        cmd_o.mem_addr = depth_m2[ADDR_W-1:0];
        state_d        = S_POP_B;
      end
      S_POP_B: begin
        cmd_o.load_b = 1'b1;
        depth_d      = depth_m2;
        state_d      = S_EXEC;
      end
      S_EXEC: begin
        if (op_q == OP_DIV) begin
          if (status_i.a_zero) begin
            emit_d  = ST_DIVZERO;
            depth_d = '0;
            state_d = S_EMIT;
          end else begin
            cmd_o.div_start = 1'b1;
            state_d         = S_DIV;
          end
        end else begin
          cmd_o.alu_go = 1'b1;
          state_d      = S_WRITE;
        end
      end
      S_DIV: begin
        if (status_i.div_done) begin
          state_d = S_WRITE;
        end
      end
      S_WRITE: begin
        cmd_o.mem_we   = 1'b1;
        cmd_o.mem_addr = depth_q[ADDR_W-1:0];
        depth_d        = depth_q + DEPTH_W'(1);
        state_d        = S_IDLE;
      end
      S_EMIT: begin
        if (status_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      depth_q <= '0;
      op_q    <= OP_ADD;
      emit_q  <= ST_VALUE;
    end else begin
      state_q <= state_d;
      depth_q <= depth_d;
      op_q    <= op_d;
      emit_q  <= emit_d;
    end
  end

endmodule

`default_nettype wire

### rtl/core/rpn_stack_calculator_unit.sv
// ----------------------------------------------------------------------------
// rpn stack calculator unit
// postfix expression evaluator on a 64-entry operand stack, 32-bit wrapping
// ----------------------------------------------------------------------------
// usage:
//   char_i takes one ascii character per beat; res_o gives status and value.
//   digits push 0..9, + - * / pop two and push the result, = emits the top.
//   underflow, overflow and divide by zero emit an error beat with value zero
//   and empty the stack; all other characters are dropped with no beat.
// controller states per character:
//   ignored character or digit push: handled in S_IDLE alone
//   =, overflow or underflow: S_EMIT, which loads the result register
//   + - *: S_POP_A, S_POP_B, S_EXEC, S_WRITE; / adds S_DIV for the divider;
//   divide by zero ends in S_EMIT; the single-port stack memory has a registered
//   read, so the two pops are taken in turn; the divider sets the worst case
// reset clears the depth count, the controller and the result valid flag;
//   stack contents are not cleared and never read before being written.
// when res_o stalls, one result waits in the output register and the next
//   character is still taken; only a second result waits for the slot.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rpn_stack_calculator_unit
  import rpn_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  rpn_char_if.sink  char_i,
  rpn_res_if.source res_o
);

  ctrl_cmd_t         cmd;
  dp_status_t        dp_status;
  logic [DATA_W-1:0] res_value;

  rpn_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (char_i.valid),
    .character_i (char_i.character),
    .in_ready_o  (char_i.ready),
    .status_i    (dp_status),
    .cmd_o       (cmd)
  );

  rpn_datapath u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .character_i  (char_i.character),
    .cmd_i        (cmd),
    .status_o     (dp_status),
    .res_valid_o  (res_o.valid),
    .res_ready_i  (res_o.ready),
    .res_status_o (res_o.status),
    .res_value_o  (res_value)
  );

  assign res_o.result_value = $signed(res_value);

endmodule

`default_nettype wire

### rtl/core/rpn_checker.sv
// ----------------------------------------------------------------------------
// rpn port checker
// port-level properties of the calculator, bound to the top level
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "rpn_stack_calculator_unit_defines.svh"

module rpn_checker
  import rpn_pkg::*;
(
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        in_valid_i,
  input wire logic        in_ready_i,
  input wire logic [7:0]  in_character_i,
  input wire logic        out_valid_i,
  input wire logic        out_ready_i,
  input wire logic [1:0]  out_status_i,
  input wire logic [31:0] out_value_i
);

  logic in_beat_digit;

  assign in_beat_digit = in_valid_i && in_ready_i &&
                         (in_character_i >= CHAR_ZERO) && (in_character_i <= CHAR_NINE);

  `RPN_ASSERT_NEXT(a_out_valid_held, out_valid_i && !out_ready_i, out_valid_i)
  `RPN_ASSERT_NEXT(a_out_beat_stable, out_valid_i && !out_ready_i, $stable(out_value_i) && $stable(out_status_i))
  `RPN_ASSERT_NOW(a_error_value_zero, out_valid_i && (out_status_i != ST_VALUE), out_value_i == '0)
  `RPN_ASSERT_NEXT(a_digit_no_quick_result, in_beat_digit, !$rose(out_valid_i))

endmodule

bind rpn_stack_calculator_unit rpn_checker u_rpn_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (char_i.valid),
  .in_ready_i     (char_i.ready),
  .in_character_i (char_i.character),
  .out_valid_i    (res_o.valid),
  .out_ready_i    (res_o.ready),
  .out_status_i   (res_o.status),
  .out_value_i    (res_o.result_value)
);

`default_nettype wire
